>>> src/scsa_pkg.sv
// Shared types and constants of the size-class slot allocator.
`timescale 1ns / 1ps

package scsa_pkg;

  localparam int unsigned NUM_CLASSES = 7;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_FREE_ALL = 2'd2,
    CMD_STATS    = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_FAIL    = 2'd1,
    STS_IGNORED = 2'd2,
    STS_UNUSED  = 2'd3
  } status_t;

  // log2 of slot size per class, 8 B up to 2 MiB
  localparam logic [4:0] CLASS_SHIFT [NUM_CLASSES] = '{
    5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21
  };

  localparam logic [2:0] LAST_CLASS = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  owner;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [2:0]  class_index;
    logic [12:0] used_count;
    logic        last;
  } out_res_t;

endpackage

>>> src/scsa_owner_ram.sv
// Owner table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module scsa_owner_ram #(
  parameter int unsigned DEPTH = 16896,
  parameter int unsigned WIDTH = 9,
  parameter int unsigned AW    = 15
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read entry, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/size_class_slot_allocator.sv
// Top level of the size-class slot allocator: sequencer, scan unit and counters.
//
//  channel   ports                          direction  meaning
//  in        in_valid/in_ready/in_req       in         one command request
//  out       out_valid/out_ready/out_res    out        result items
//  cfg       cfg_we/cfg_wdata               in         region_base write
//
// Alloc runs a first-free scan of its class through the single owner table
// port at one entry per cycle. Free makes one region compare per cycle,
// free-all a scan of every class region, and stats gives 7 results at one
// per cycle while the output is not stalled. After reset a clearing pass
// writes all 4*SMALL+MID+LARGE+HUGE entries, one per cycle, with in_ready
// low. A stalled result holds the output register; the next request is
// taken meanwhile and its result waits until the register frees.
`timescale 1ns / 1ps

module size_class_slot_allocator
  import scsa_pkg::*;
#(
  parameter int unsigned SMALL_CLASS_SLOTS = 4096,
  parameter int unsigned MID_CLASS_SLOTS   = 512,
  parameter int unsigned LARGE_CLASS_SLOTS = 64,
  parameter int unsigned HUGE_CLASS_SLOTS  = 8,
  parameter int unsigned OWNER_BITS        = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned S = SMALL_CLASS_SLOTS;
  localparam int unsigned M = MID_CLASS_SLOTS;
  localparam int unsigned L = LARGE_CLASS_SLOTS;
  localparam int unsigned H = HUGE_CLASS_SLOTS;
  localparam int unsigned TOTAL = 4 * S + M + L + H;
  localparam int unsigned AW = $clog2(TOTAL);
  localparam int unsigned MAXS = (S > M) ? ((S > L) ? ((S > H) ? S : H) : ((L > H) ? L : H))
                                         : ((M > L) ? ((M > H) ? M : H) : ((L > H) ? L : H));
  localparam int unsigned CW = $clog2(MAXS + 1);
  localparam int unsigned EW = OWNER_BITS + 1;

  localparam int unsigned SLOTS [NUM_CLASSES] = '{S, S, S, S, M, L, H};
  localparam int unsigned MEM_OFS [NUM_CLASSES] = '{
    0, S, 2 * S, 3 * S, 4 * S, 4 * S + M, 4 * S + M + L
  };
  localparam logic [32:0] SPAN [NUM_CLASSES] = '{
    33'(S) << 3, 33'(S) << 6, 33'(S) << 9, 33'(S) << 12,
    33'(M) << 15, 33'(L) << 18, 33'(H) << 21
  };
  localparam logic [32:0] OFS6 = 33'd0;
  localparam logic [32:0] OFS5 = OFS6 + SPAN[6];
  localparam logic [32:0] OFS4 = OFS5 + SPAN[5];
  localparam logic [32:0] OFS3 = OFS4 + SPAN[4];
  localparam logic [32:0] OFS2 = OFS3 + SPAN[3];
  localparam logic [32:0] OFS1 = OFS2 + SPAN[2];
  localparam logic [32:0] OFS0 = OFS1 + SPAN[1];
  localparam logic [31:0] ADDR_OFS [NUM_CLASSES] = '{
    OFS0[31:0], OFS1[31:0], OFS2[31:0], OFS3[31:0], OFS4[31:0], OFS5[31:0], OFS6[31:0]
  };

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_SCAN = 7'b0000100,
    ST_FIND = 7'b0001000,
    ST_FCHK = 7'b0010000,
    ST_EMIT = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [31:0]         region_base_r;
  cmd_t                cmd_r, cmd_nxt;
  logic [OWNER_BITS-1:0] own_r, own_nxt;
  logic [31:0]         rel_r, rel_nxt;
  logic [2:0]          cls_r, cls_nxt;
  logic [AW:0]         scan_addr_r, scan_addr_nxt;
  logic [AW:0]         scan_end_r, scan_end_nxt;
  logic                issue_r, issue_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic [31:0]         base_r, base_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [31:0]         res_addr_r, res_addr_nxt;
  logic [CW-1:0]       cnt_r [NUM_CLASSES];
  logic [CW-1:0]       cnt_nxt [NUM_CLASSES];
  logic                out_valid_r, out_valid_nxt;
  out_res_t            out_res_r, out_res_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  logic [OWNER_BITS+7:0] owner_ext;
  logic [EW-1:0]       own_tag;
  logic                fit_found;
  logic [2:0]          fit_cls;
  logic [31:0]         find_off;
  logic                find_hit;
  logic [31:0]         find_idx;
  logic [AW-1:0]       find_addr;
  logic [AW-1:0]       loc_idx;
  logic [31:0]         grant_addr;
  logic [CW+12:0]      cnt_ext;

  assign owner_ext = {{OWNER_BITS{1'b0}}, in_req.owner};
  assign own_tag   = {1'b1, own_r};

  // Pick smallest fitting class
  always_comb begin
    fit_found = 1'b0;
    fit_cls   = 3'd0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (in_req.request_size <= (32'd1 << CLASS_SHIFT[k])) begin
        fit_found = 1'b1;
        fit_cls   = 3'(k);
      end
    end
  end

  // Region test for free, one class per cycle
  assign find_off  = rel_r - ADDR_OFS[cls_r];
  assign find_hit  = ({1'b0, find_off} < SPAN[cls_r]);
  assign find_idx  = find_off >> CLASS_SHIFT[cls_r];
  assign find_addr = AW'(MEM_OFS[cls_r]) + find_idx[AW-1:0];

  // Slot address of a granted entry
  assign loc_idx    = rd_addr_r - AW'(MEM_OFS[cls_r]);
  assign grant_addr = base_r + (32'(loc_idx) << CLASS_SHIFT[cls_r]);
  assign cnt_ext    = {13'd0, cnt_r[cls_r]};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    own_nxt        = own_r;
    rel_nxt        = rel_r;
    cls_nxt        = cls_r;
    scan_addr_nxt  = scan_addr_r;
    scan_end_nxt   = scan_end_r;
    issue_nxt      = 1'b0;
    rd_vld_nxt     = 1'b0;
    rd_addr_nxt    = rd_addr_r;
    base_nxt       = base_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_addr_r;
    ram_wdata      = '0;
    ram_raddr      = scan_addr_r[AW-1:0];
    in_ready       = 1'b0;

    // Drop the output item once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we        = 1'b1;
        ram_waddr     = scan_addr_r[AW-1:0];
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_addr_r == (AW+1)'(TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = cmd_t'(in_req.cmd);
          own_nxt = owner_ext[OWNER_BITS-1:0];
          rel_nxt = in_req.block_address - region_base_r;
          cls_nxt = 3'd0;
          unique case (cmd_t'(in_req.cmd))
            CMD_ALLOC: begin
              if (fit_found) begin
                cls_nxt       = fit_cls;
                base_nxt      = region_base_r + ADDR_OFS[fit_cls];
                scan_addr_nxt = (AW+1)'(MEM_OFS[fit_cls]);
                scan_end_nxt  = (AW+1)'(MEM_OFS[fit_cls] + SLOTS[fit_cls]);
                issue_nxt     = 1'b1;
                state_nxt     = ST_SCAN;
              end else begin
                res_status_nxt = STS_FAIL;
                res_addr_nxt   = '0;
                state_nxt      = ST_EMIT;
              end
            end
            CMD_FREE: begin
              state_nxt = ST_FIND;
            end
            CMD_FREE_ALL: begin
              scan_addr_nxt = (AW+1)'(MEM_OFS[0]);
              scan_end_nxt  = (AW+1)'(MEM_OFS[0] + SLOTS[0]);
              issue_nxt     = 1'b1;
              state_nxt     = ST_SCAN;
            end
            CMD_STATS: begin
              res_status_nxt = STS_DONE;
              res_addr_nxt   = '0;
              state_nxt      = ST_EMIT;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read
        if (issue_r) begin
          scan_addr_nxt = scan_addr_r + 1'b1;
          rd_vld_nxt    = 1'b1;
          rd_addr_nxt   = scan_addr_r[AW-1:0];
          issue_nxt     = (scan_addr_r + 1'b1 != scan_end_r);
        end
        // Check the returned entry
        if (rd_vld_r) begin
          if (cmd_r == CMD_ALLOC) begin
            if (!ram_rdata[EW-1]) begin
              ram_we         = 1'b1;
              ram_wdata      = own_tag;
              cnt_nxt[cls_r] = cnt_r[cls_r] + 1'b1;
              res_status_nxt = STS_DONE;
              res_addr_nxt   = grant_addr;
              issue_nxt      = 1'b0;
              rd_vld_nxt     = 1'b0;
              state_nxt      = ST_EMIT;
            end else if (rd_addr_r == AW'(scan_end_r - 1'b1)) begin
              res_status_nxt = STS_FAIL;
              res_addr_nxt   = '0;
              state_nxt      = ST_EMIT;
            end
          end else begin
            if (ram_rdata == own_tag) begin
              ram_we         = 1'b1;
              cnt_nxt[cls_r] = cnt_r[cls_r] - 1'b1;
            end
            if (rd_addr_r == AW'(scan_end_r - 1'b1)) begin
              if (cls_r == LAST_CLASS) begin
                res_status_nxt = STS_DONE;
                res_addr_nxt   = '0;
                cls_nxt        = 3'd0;
                state_nxt      = ST_EMIT;
              end else begin
                cls_nxt       = cls_r + 1'b1;
                scan_addr_nxt = (AW+1)'(MEM_OFS[cls_r + 1'b1]);
                scan_end_nxt  = (AW+1)'(MEM_OFS[cls_r + 1'b1] + SLOTS[cls_r + 1'b1]);
                issue_nxt     = 1'b1;
              end
            end
          end
        end
      end

      ST_FIND: begin
        ram_raddr = find_addr;
        if (find_hit) begin
          rd_addr_nxt = find_addr;
          state_nxt   = ST_FCHK;
        end else if (cls_r == LAST_CLASS) begin
          res_status_nxt = STS_IGNORED;
          res_addr_nxt   = '0;
          cls_nxt        = 3'd0;
          state_nxt      = ST_EMIT;
        end else begin
          cls_nxt = cls_r + 1'b1;
        end
      end

      ST_FCHK: begin
        res_addr_nxt = '0;
        if (ram_rdata == own_tag) begin
          ram_we         = 1'b1;
          cnt_nxt[cls_r] = cnt_r[cls_r] - 1'b1;
          res_status_nxt = STS_DONE;
        end else begin
          res_status_nxt = STS_IGNORED;
        end
        cls_nxt   = 3'd0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        // Load the result once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_res_nxt.status          = res_status_r;
          out_res_nxt.granted_address = res_addr_r;
          if (cmd_r == CMD_STATS) begin
            out_res_nxt.class_index = cls_r;
            out_res_nxt.used_count  = cnt_ext[12:0];
            out_res_nxt.last        = (cls_r == LAST_CLASS);
            if (cls_r == LAST_CLASS) begin
              state_nxt = ST_IDLE;
            end else begin
              cls_nxt = cls_r + 1'b1;
            end
          end else begin
            out_res_nxt.class_index = 3'd0;
            out_res_nxt.used_count  = 13'd0;
            out_res_nxt.last        = 1'b1;
            state_nxt               = ST_IDLE;
          end
        end
      end

      ST_SPARE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      scan_addr_r   <= '0;
      issue_r       <= 1'b0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      region_base_r <= 32'h0010_0000;
      cls_r         <= 3'd0;
      cmd_r         <= CMD_ALLOC;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cls_r       <= cls_nxt;
      cmd_r       <= cmd_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        region_base_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    own_r        <= own_nxt;
    rel_r        <= rel_nxt;
    scan_end_r   <= scan_end_nxt;
    rd_addr_r    <= rd_addr_nxt;
    base_r       <= base_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_res_r    <= out_res_nxt;
  end

  scsa_owner_ram #(
    .DEPTH (TOTAL),
    .WIDTH (EW),
    .AW    (AW)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Table writes happen only while a request is at work or clearing
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_IDLE && state_r != ST_EMIT))
    else $error("owner table written while idle");

  // The class at cls_r never counts more used slots than it has
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r[cls_r]) <= SLOTS[cls_r])
    else $error("used count exceeds class size");

  // An accepted request leaves idle on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("request accepted without starting work");

  // A failed or ignored result never carries an address
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != STS_DONE) |-> (out_res.granted_address == 32'd0))
    else $error("address on a failed result");

endmodule
